// ===== hw/rtl/sha256_hash_engine_top_defines.svh =====
// ----------------------------------------------------------------------------
// sha256_hash_engine_top_defines.svh
// Assertion macros for the SHA-256 engine checker.
// ----------------------------------------------------------------------------
`ifndef SHA256_HASH_ENGINE_TOP_DEFINES_SVH
`define SHA256_HASH_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define SHA_AST_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, clocked on i_clk, off during reset.
`define SHA_AST_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/sha256_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_pkg
// Types, round constants and helper functions for the SHA-256 engine.
// ----------------------------------------------------------------------------
package sha256_pkg;

    localparam logic [31:0] K_ROUND [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_MARK    = 8'h80;
    localparam logic [5:0] POS_LAST    = 6'd63;
    localparam logic [5:0] POS_LEN     = 6'd56;
    localparam logic [5:0] RND_LAST    = 6'd63;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PAD,
        S_COMP,
        S_FIN
    } t_state;

    typedef enum logic [1:0] {
        BSEL_IN,
        BSEL_MARK,
        BSEL_ZERO,
        BSEL_LEN
    } t_bsel;

    typedef struct packed {
        logic       shift_en;
        t_bsel      bsel;
        logic [2:0] len_idx;
        logic       len_add;
        logic       init_work;
        logic       round_en;
        logic [5:0] rnd;
        logic       chain_add;
        logic       digest_cap;
    } t_ctl;

    typedef logic [31:0] t_word8 [8];

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

// ===== hw/rtl/sha256_round.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_round
// Shared round unit: one compression round and one schedule word per use.
// ----------------------------------------------------------------------------
module sha256_round (
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_c,
    input  logic [31:0] i_d,
    input  logic [31:0] i_e,
    input  logic [31:0] i_f,
    input  logic [31:0] i_g,
    input  logic [31:0] i_h,
    input  logic [31:0] i_k,
    input  logic [31:0] i_w0,
    input  logic [31:0] i_w1,
    input  logic [31:0] i_w9,
    input  logic [31:0] i_w14,
    output logic [31:0] o_a,
    output logic [31:0] o_e,
    output logic [31:0] o_w_new
);

    logic [31:0] w_t1;
    logic [31:0] w_t2;

    assign w_t1 = i_h + sha256_pkg::bsig1(i_e) + ((i_e & i_f) ^ (~i_e & i_g)) + i_k + i_w0;
    assign w_t2 = sha256_pkg::bsig0(i_a) + ((i_a & i_b) ^ (i_a & i_c) ^ (i_b & i_c));
    assign o_a  = w_t1 + w_t2;
    assign o_e  = i_d + w_t1;

    // word sixteen ahead of the current one
    assign o_w_new = sha256_pkg::ssig1(i_w14) + i_w9 + sha256_pkg::ssig0(i_w1) + i_w0;

endmodule

// ===== hw/rtl/sha256_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_ctrl
// Sequencer: byte fill, padding, round count and digest hand-off.
// ----------------------------------------------------------------------------
module sha256_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_has_byte,
    input  logic              i_end_of_message,
    input  logic              i_out_busy,
    output logic              o_in_ready,
    output sha256_pkg::t_ctl  o_ctl
);

    sha256_pkg::t_state r_state, n_state;
    logic [5:0] r_pos, n_pos;
    logic [5:0] r_rnd, n_rnd;
    logic       r_eom, n_eom;
    logic       r_first, n_first;
    logic       r_final, n_final;
    logic       r_padding, n_padding;
    logic       w_acc;

    assign w_acc = (r_state == sha256_pkg::S_IDLE) && i_in_valid;

    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_rnd     = r_rnd;
        n_eom     = r_eom;
        n_first   = r_first;
        n_final   = r_final;
        n_padding = r_padding;
        case (r_state)
            sha256_pkg::S_IDLE: begin
                if (w_acc) begin
                    if (i_has_byte) begin
                        n_pos = r_pos + 6'd1;
                    end
                    if (i_has_byte && r_pos == sha256_pkg::POS_LAST) begin
                        n_state = sha256_pkg::S_COMP;
                        n_rnd   = '0;
                        n_eom   = i_end_of_message;
                    end else if (i_end_of_message) begin
                        n_state   = sha256_pkg::S_PAD;
                        n_first   = 1'b1;
                        n_padding = 1'b1;
                    end
                end
            end
            sha256_pkg::S_PAD: begin
                n_pos   = r_pos + 6'd1;
                n_first = 1'b0;
                if (r_first) begin
                    n_final = (r_pos < sha256_pkg::POS_LEN);
                end
                if (r_pos == sha256_pkg::POS_LAST) begin
                    n_state = sha256_pkg::S_COMP;
                    n_rnd   = '0;
                end
            end
            sha256_pkg::S_COMP: begin
                n_rnd = r_rnd + 6'd1;
                if (r_rnd == sha256_pkg::RND_LAST) begin
                    n_state = sha256_pkg::S_FIN;
                end
            end
            sha256_pkg::S_FIN: begin
                if (r_padding && r_final) begin
                    // hold until the previous digest is taken
                    if (!i_out_busy) begin
                        n_state   = sha256_pkg::S_IDLE;
                        n_padding = 1'b0;
                        n_final   = 1'b0;
                    end
                end else if (r_padding) begin
                    n_state = sha256_pkg::S_PAD;
                    n_final = 1'b1;
                end else if (r_eom) begin
                    n_state   = sha256_pkg::S_PAD;
                    n_first   = 1'b1;
                    n_padding = 1'b1;
                    n_eom     = 1'b0;
                end else begin
                    n_state = sha256_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sha256_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_ctl          = '0;
        o_ctl.bsel     = sha256_pkg::BSEL_IN;
        o_ctl.len_idx  = r_pos[2:0];
        o_ctl.rnd      = r_rnd;
        case (r_state)
            sha256_pkg::S_IDLE: begin
                o_in_ready      = 1'b1;
                o_ctl.shift_en  = w_acc && i_has_byte;
                o_ctl.len_add   = w_acc && i_has_byte;
                o_ctl.init_work = w_acc && i_has_byte && (r_pos == sha256_pkg::POS_LAST);
            end
            sha256_pkg::S_PAD: begin
                o_ctl.shift_en  = 1'b1;
                o_ctl.init_work = (r_pos == sha256_pkg::POS_LAST);
                if (r_first) begin
                    o_ctl.bsel = sha256_pkg::BSEL_MARK;
                end else if (r_final && r_pos >= sha256_pkg::POS_LEN) begin
                    o_ctl.bsel = sha256_pkg::BSEL_LEN;
                end else begin
                    o_ctl.bsel = sha256_pkg::BSEL_ZERO;
                end
            end
            sha256_pkg::S_COMP: begin
                o_ctl.round_en = 1'b1;
            end
            sha256_pkg::S_FIN: begin
                o_ctl.chain_add  = !(r_padding && r_final);
                o_ctl.digest_cap = r_padding && r_final && !i_out_busy;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sha256_pkg::S_IDLE;
            r_pos     <= '0;
            r_rnd     <= '0;
            r_eom     <= 1'b0;
            r_first   <= 1'b0;
            r_final   <= 1'b0;
            r_padding <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pos     <= n_pos;
            r_rnd     <= n_rnd;
            r_eom     <= n_eom;
            r_first   <= n_first;
            r_final   <= n_final;
            r_padding <= n_padding;
        end
    end

endmodule

// ===== hw/rtl/sha256_hash_engine_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_hash_engine_top
// SHA-256 over a byte stream; one 256-bit digest per message.
// ----------------------------------------------------------------------------
//  channel  | handshake                    | payload
//  ---------+------------------------------+-----------------------------------
//  in       | i_in_valid / o_in_ready      | has_byte, msg_byte, end_of_message
//  out      | o_out_valid / i_out_ready    | digest_hi .. digest_lo
//
//  A plain byte item that fills no block leaves input ready; one that fills a
//  64-byte block adds 64 rounds on the shared round unit plus one chaining add.
//  An end item adds 9 to 72 padding bytes (one byte a cycle) and one or two
//  compressions. Reset clears the sequencer and loads the initial hash.
//  A pending digest does not block input; a second digest waits for it.
// ----------------------------------------------------------------------------
module sha256_hash_engine_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_has_byte,
    input  logic [7:0]  i_msg_byte,
    input  logic        i_end_of_message,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_digest_hi,
    output logic [63:0] o_digest_mid_hi,
    output logic [63:0] o_digest_mid_lo,
    output logic [63:0] o_digest_lo
);

    sha256_pkg::t_ctl w_ctl;
    logic [511:0] r_blk;
    logic [63:0]  r_len;
    logic [31:0]  r_chain [8];
    logic [31:0]  r_work  [8];
    logic         r_ovalid;
    logic [63:0]  r_dig   [4];
    logic [63:0]  w_lsh;
    logic [7:0]   w_byte;
    logic [31:0]  w_a_new;
    logic [31:0]  w_e_new;
    logic [31:0]  w_w_new;
    logic [31:0]  w_sum   [8];

    sha256_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_has_byte       (i_has_byte),
        .i_end_of_message (i_end_of_message),
        .i_out_busy       (r_ovalid && !i_out_ready),
        .o_in_ready       (o_in_ready),
        .o_ctl            (w_ctl)
    );

    sha256_round u_round (
        .i_a     (r_work[0]),
        .i_b     (r_work[1]),
        .i_c     (r_work[2]),
        .i_d     (r_work[3]),
        .i_e     (r_work[4]),
        .i_f     (r_work[5]),
        .i_g     (r_work[6]),
        .i_h     (r_work[7]),
        .i_k     (sha256_pkg::K_ROUND[w_ctl.rnd]),
        .i_w0    (r_blk[511:480]),
        .i_w1    (r_blk[479:448]),
        .i_w9    (r_blk[223:192]),
        .i_w14   (r_blk[63:32]),
        .o_a     (w_a_new),
        .o_e     (w_e_new),
        .o_w_new (w_w_new)
    );

    // length byte, most significant first
    assign w_lsh = r_len << {w_ctl.len_idx, 3'b000};

    always_comb begin
        case (w_ctl.bsel)
            sha256_pkg::BSEL_IN:   w_byte = i_msg_byte;
            sha256_pkg::BSEL_MARK: w_byte = sha256_pkg::PAD_MARK;
            sha256_pkg::BSEL_LEN:  w_byte = w_lsh[63:56];
            default:               w_byte = '0;
        endcase
    end

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            w_sum[k] = r_chain[k] + r_work[k];
        end
    end

    // block buffer and schedule window share one shift line
    always_ff @(posedge i_clk) begin
        if (w_ctl.shift_en) begin
            r_blk <= {r_blk[503:0], w_byte};
        end else if (w_ctl.round_en) begin
            r_blk <= {r_blk[479:0], w_w_new};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.init_work) begin
            r_work <= r_chain;
        end else if (w_ctl.round_en) begin
            r_work[0] <= w_a_new;
            r_work[1] <= r_work[0];
            r_work[2] <= r_work[1];
            r_work[3] <= r_work[2];
            r_work[4] <= w_e_new;
            r_work[5] <= r_work[4];
            r_work[6] <= r_work[5];
            r_work[7] <= r_work[6];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= sha256_pkg::H_INIT;
            r_len   <= '0;
        end else if (w_ctl.digest_cap) begin
            r_chain <= sha256_pkg::H_INIT;
            r_len   <= '0;
        end else begin
            if (w_ctl.chain_add) begin
                r_chain <= w_sum;
            end
            if (w_ctl.len_add) begin
                r_len <= r_len + 64'd8;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_ctl.digest_cap) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.digest_cap) begin
            r_dig[0] <= {w_sum[0], w_sum[1]};
            r_dig[1] <= {w_sum[2], w_sum[3]};
            r_dig[2] <= {w_sum[4], w_sum[5]};
            r_dig[3] <= {w_sum[6], w_sum[7]};
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_digest_hi     = r_dig[0];
    assign o_digest_mid_hi = r_dig[1];
    assign o_digest_mid_lo = r_dig[2];
    assign o_digest_lo     = r_dig[3];

endmodule

// ===== hw/rtl/sha256_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_chk
// Port-level checks for the SHA-256 engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "sha256_hash_engine_top_defines.svh"

module sha256_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic i_has_byte,
    input logic i_end_of_message,
    input logic o_out_valid,
    input logic i_out_ready
);

    `SHA_AST_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)
    `SHA_AST_NXT(a_eom_busy, i_in_valid && o_in_ready && i_end_of_message, !o_in_ready)
    `SHA_AST_NXT(a_idle_item, i_in_valid && o_in_ready && !i_has_byte && !i_end_of_message, o_in_ready)
    `SHA_AST_IMP(a_digest_src, $rose(o_out_valid), $past(!o_in_ready))

endmodule

bind sha256_hash_engine_top sha256_chk u_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .i_has_byte       (i_has_byte),
    .i_end_of_message (i_end_of_message),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready)
);
